// File: rtl/lefd_pkg.sv
// Package for the little-endian and LEB128 field decoder.
// Holds the type codes, field widths, shared structs and the fixed-size table.
// No dependencies; every module of the decoder imports it.
`timescale 1ns / 1ps

package lefd_pkg;

    localparam int VALUE_BITS = 64;
    localparam int OUT_BITS   = 64;
    localparam int OUT_IDX_W  = $clog2(OUT_BITS);
    localparam int DATA_W     = 8;
    localparam int CMD_W      = 4;
    localparam int CNT_W      = 4;
    localparam int SHIFT_W    = 7;
    localparam int POS_W      = SHIFT_W + 1;
    localparam int LEB_GROUP  = 7;
    localparam int LEB_CONT   = 7;
    localparam int LEB_SIGN   = 6;
    localparam logic [CNT_W-1:0] CNT_MAX = 4'hF;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 72;
    localparam int M_PAD_W   = M_TDATA_W - OUT_BITS - CNT_W - 1;

    typedef enum logic [CMD_W-1:0] {
        TYPE_BOOL = 4'd0,
        TYPE_U8   = 4'd1,
        TYPE_I8   = 4'd2,
        TYPE_U16  = 4'd3,
        TYPE_I16  = 4'd4,
        TYPE_U32  = 4'd5,
        TYPE_I32  = 4'd6,
        TYPE_U64  = 4'd7,
        TYPE_I64  = 4'd8,
        TYPE_ULEB = 4'd9,
        TYPE_SLEB = 4'd10
    } type_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic [CMD_W-1:0]  command;
    } in_item_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        type_t               value_type;
        logic [CNT_W-1:0]    byte_count;
        logic                overflow;
    } result_t;

    function automatic logic [CNT_W-1:0] fixed_size(input type_t t);
        logic [CNT_W-1:0] size;
        unique case (t)
            TYPE_U16, TYPE_I16: size = 4'd2;
            TYPE_U32, TYPE_I32: size = 4'd4;
            TYPE_U64, TYPE_I64: size = 4'd8;
            default:            size = 4'd1;
        endcase
        return size;
    endfunction

endpackage

// File: rtl/lefd_in_reg.sv
// Input register stage of the field decoder.
// Holds one byte transaction until the decode core takes it; depends on lefd_pkg.
`timescale 1ns / 1ps

module lefd_in_reg
    import lefd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [CMD_W-1:0]     s_axis_tuser,
    output logic                 item_valid,
    output in_item_t             item,
    input  logic                 item_take
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_axis_tready = !valid_reg || item_take;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.data_byte <= s_axis_tdata[DATA_W-1:0];
            item_reg.command   <= s_axis_tuser;
        end
    end

endmodule

// File: rtl/lefd_core.sv
// Decode core of the field decoder: value state and the per-byte update.
// Gathers fixed-size and LEB128 fields and forms the result; depends on lefd_pkg.
`timescale 1ns / 1ps

module lefd_core
    import lefd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  in_item_t item,
    output logic     item_take,
    input  logic     out_free,
    output logic     res_valid,
    output result_t  res
);

    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    type_t                 type_reg;
    type_t                 type_next;
    logic                  prog_reg;
    logic                  prog_next;
    logic                  ovf_reg;
    logic                  ovf_next;

    logic                  start;
    logic                  bad;
    type_t                 typ;
    logic [VALUE_BITS-1:0] acc_eff;
    logic [CNT_W-1:0]      cnt_eff;
    logic                  ovf_eff;
    logic                  is_leb;
    logic                  leb_signed;
    logic                  fix_signed;
    logic [SHIFT_W-1:0]    leb_shift;
    logic [POS_W-1:0]      leb_pos;
    logic [POS_W-1:0]      leb_end;
    logic [LEB_GROUP-1:0]  grp;
    logic [VALUE_BITS-1:0] leb_or;
    logic [VALUE_BITS-1:0] leb_acc;
    logic                  leb_sign;
    logic                  lost;
    logic [OUT_BITS-1:0]   leb_value;
    logic [SHIFT_W-1:0]    fix_shift;
    logic [VALUE_BITS-1:0] fix_or;
    logic [CNT_W-1:0]      size;
    logic                  fix_done;
    logic [SHIFT_W-1:0]    top;
    logic [SHIFT_W-1:0]    sbit;
    logic [OUT_BITS-1:0]   fix_z;
    logic [OUT_BITS-1:0]   fix_value;
    logic                  done;
    logic                  fire;

    always_comb
    begin
        start   = !prog_reg;
        bad     = start && (item.command > CMD_W'(TYPE_SLEB));
        typ     = start ? type_t'(item.command) : type_reg;
        acc_eff = start ? '0 : acc_reg;
        cnt_eff = start ? '0 : cnt_reg;
        ovf_eff = start ? 1'b0 : ovf_reg;

        is_leb     = (typ == TYPE_ULEB) || (typ == TYPE_SLEB);
        leb_signed = (typ == TYPE_SLEB);
        fix_signed = (typ == TYPE_I8) || (typ == TYPE_I16) || (typ == TYPE_I32)
                     || (typ == TYPE_I64);

        // LEB128 path: place the 7-bit group, track bits that fall off the top.
        grp       = item.data_byte[LEB_GROUP-1:0];
        leb_shift = SHIFT_W'(cnt_eff) * SHIFT_W'(LEB_GROUP);
        leb_or    = acc_eff | (VALUE_BITS'(grp) << leb_shift);
        leb_sign  = leb_or[VALUE_BITS-1];
        lost      = 1'b0;
        for (int i = 0; i < LEB_GROUP; i++)
        begin
            leb_pos = POS_W'(leb_shift) + POS_W'(i);
            if ((leb_pos >= POS_W'(VALUE_BITS))
                && (grp[i] != (leb_signed ? leb_sign : 1'b0)))
            begin
                lost = 1'b1;
            end
        end
        leb_end = POS_W'(leb_shift) + POS_W'(LEB_GROUP);
        leb_acc = leb_or;
        if (leb_signed && !item.data_byte[LEB_CONT] && item.data_byte[LEB_SIGN]
            && (leb_end < POS_W'(VALUE_BITS)))
        begin
            leb_acc = leb_or | ({VALUE_BITS{1'b1}} << leb_end);
        end
        leb_value = leb_signed ? OUT_BITS'(signed'(leb_acc)) : OUT_BITS'(leb_acc);

        // Fixed-size path: place the byte by position, extend at the field top.
        fix_shift = SHIFT_W'(cnt_eff) << 3;
        fix_or    = acc_eff | (VALUE_BITS'(item.data_byte) << fix_shift);
        size      = fixed_size(typ);
        fix_done  = ({1'b0, cnt_eff} + 5'd1) >= {1'b0, size};
        top       = SHIFT_W'(size) << 3;
        if (top > SHIFT_W'(VALUE_BITS))
        begin
            top = SHIFT_W'(VALUE_BITS);
        end
        sbit      = top - SHIFT_W'(1);
        fix_z     = OUT_BITS'(fix_or);
        fix_value = fix_z;
        if (typ == TYPE_BOOL)
        begin
            fix_value = OUT_BITS'(fix_or != '0);
        end
        else if (fix_signed && fix_z[sbit[OUT_IDX_W-1:0]])
        begin
            fix_value = fix_z | ({OUT_BITS{1'b1}} << sbit);
        end

        done      = is_leb ? !item.data_byte[LEB_CONT] : fix_done;
        item_take = item_valid && (bad || !done || out_free);
        fire      = item_take && !bad;

        cnt_next  = (cnt_eff == CNT_MAX) ? cnt_eff : cnt_eff + CNT_W'(1);
        acc_next  = is_leb ? leb_acc : fix_or;
        ovf_next  = ovf_eff || (is_leb && lost);
        type_next = typ;
        prog_next = prog_reg;
        if (fire)
        begin
            prog_next = !done;
        end

        res_valid      = fire && done;
        res.value      = is_leb ? leb_value : fix_value;
        res.value_type = typ;
        res.byte_count = cnt_next;
        res.overflow   = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            type_reg <= TYPE_BOOL;
            prog_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            prog_reg <= prog_next;
            if (fire)
            begin
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
                type_reg <= type_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

endmodule

// File: rtl/lefd_out_reg.sv
// Output register stage of the field decoder.
// Holds one result transaction until the receiver takes it; depends on lefd_pkg.
`timescale 1ns / 1ps

module lefd_out_reg
    import lefd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  result_t              res,
    output logic                 out_free,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [CMD_W-1:0]     m_axis_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {M_PAD_W'(0), res_reg.overflow, res_reg.byte_count, res_reg.value};
    assign m_axis_tuser  = res_reg.value_type;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// File: rtl/le_and_leb128_field_decoder.sv
// Top level of the little-endian and LEB128 field decoder.
// Instantiates lefd_in_reg, lefd_core and lefd_out_reg; depends on lefd_pkg.
//
// The slave channel carries one byte of a serialized stream per transaction
// in s_axis_tdata, with the type code in s_axis_tuser. The type code is taken
// only on the first byte of a value; codes above the signed LEB128 code on a
// first byte are dropped without a result. Fixed-size types end after their
// byte count, LEB128 types on a byte whose top bit is clear.
// Each completed value gives one master transaction: the 64-bit value,
// sign-extended for signed types, the byte count saturating at 15, an
// overflow flag for LEB128 bits lost above 64, and the type code in tuser.
// Throughput is one byte per cycle unless a finished value waits for the output
// register; the accumulator update is a single shift and OR into a 64-bit
// register. A value's last byte is held at the input, then its result at the output.
// Reset clears both channel registers and returns the decoder to idle with an
// empty accumulator. When the receiver stalls, the held result waits in the
// output register, one more byte is buffered at the input, and bytes that do
// not finish a value continue to be taken.
`timescale 1ns / 1ps

module le_and_leb128_field_decoder
    import lefd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // data_byte[7:0]
    input  logic [CMD_W-1:0]     s_axis_tuser,  // command[3:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // value[63:0], byte_count[67:64], overflow[68]
    output logic [CMD_W-1:0]     m_axis_tuser   // value_type[3:0]
);

    logic     item_valid;
    in_item_t item;
    logic     item_take;
    logic     out_free;
    logic     res_valid;
    result_t  res;

    lefd_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    lefd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    lefd_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Every emitted value consumed at least one byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[67:64] != '0))
        else $error("Result with zero byte count.");

    // Overflow can only be reported for LEB128 values.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[68]) |->
            ((m_axis_tuser == TYPE_ULEB) || (m_axis_tuser == TYPE_SLEB)))
        else $error("Overflow flagged on a fixed-size value.");

    // A bool is one byte and decodes to zero or one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == TYPE_BOOL)) |->
            ((m_axis_tdata[63:1] == '0) && (m_axis_tdata[67:64] == 4'd1)))
        else $error("Malformed bool result.");

    // The core never produces a result while a held result is not being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("Result would overwrite a pending transaction.");

endmodule
